FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL; empty when built for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define RDQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rdq assertion failed");
// condition that must hold at every clock edge outside reset
`define RDQ_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rdq invariant broken");
`else
`define RDQ_ASSERT(label, clk, rst_n, prop)
`define RDQ_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

FILE: hdl/rdq_pkg.sv
// Types, codes and ring-pointer helpers for the record deque.
package rdq_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SW    = AW + 2;

	localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
	localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
	localparam logic [3:0] FN_POP_FRONT  = 4'd2;
	localparam logic [3:0] FN_POP_BACK   = 4'd3;
	localparam logic [3:0] FN_PEEK_FRONT = 4'd4;
	localparam logic [3:0] FN_PEEK_BACK  = 4'd5;
	localparam logic [3:0] FN_MAX_AGE    = 4'd6;
	localparam logic [3:0] FN_MIN_CODE   = 4'd7;
	localparam logic [3:0] FN_DELETE     = 4'd8;
	localparam logic [3:0] FN_CLEAR      = 4'd9;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] record_code;
		logic [7:0]         record_age;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_code;
		logic [7:0]         out_age;
		logic [6:0]         count;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] code;
		logic [7:0]         age;
	} entry_t;

	typedef enum logic [1:0] {
		CMP_AGE_GT,
		CMP_CODE_LT,
		CMP_CODE_NE
	} cmp_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_DEL
	} state_t;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH))
			sum = sum - SW'(DEPTH);
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

endpackage

FILE: hdl/rdq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module rdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rdq_cmp.sv
// Shared record comparator used by the max, min and delete walks.
module rdq_cmp (
	input  rdq_pkg::cmp_mode_t mode,
	input  rdq_pkg::entry_t    cand,
	input  rdq_pkg::entry_t    ref_entry,
	output logic               hit
);
	import rdq_pkg::*;

	always_comb begin
		case (mode)
			CMP_AGE_GT:  hit = cand.age > ref_entry.age;
			CMP_CODE_LT: hit = cand.code < ref_entry.code;
			CMP_CODE_NE: hit = cand.code != ref_entry.code;
			default:     hit = 1'b0;
		endcase
	end

endmodule

FILE: hdl/record_deque_with_scans.sv
// Top level of the record deque: sequencer, pointers and ring store.
//
//   channel   direction  handshake             payload
//   command   in         start, busy           cmd    (in_word_t)
//   result    out        done (one-cycle)      result (out_word_t)
//
// Push, clear, unused codes and any empty or full outcome raise done from S_EXEC;
// pop and peek on a held record raise it from S_POP.
// Max, min and delete walk the held records through the single RAM read port,
// one record a cycle.
// busy is high from the cycle after start until done; done lasts one cycle and
// the receiver cannot stall it. Reset clears front pointer and count; store is not swept.
module record_deque_with_scans (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rdq_pkg::in_word_t  cmd,
	output logic               done,
	output rdq_pkg::out_word_t result
);
	import rdq_pkg::*;

	state_t          state_q, state_d;
	in_word_t        cmd_q;
	logic [AW-1:0]   front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
	logic [CW-1:0]   left_q, left_d;
	logic [CW-1:0]   kept_q, kept_d;
	logic            vld_s1, vld_d;
	logic            have_q, have_d;
	entry_t          best_q, best_d;
	out_word_t       res_q, res_d;
	logic            done_q, done_d;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	entry_t          ram_wdata, ram_rdata;

	cmp_mode_t       cmp_mode;
	entry_t          cmp_ref;
	logic            cmp_hit;

	logic            empty, full;
	logic [CW-1:0]   ring_off;
	logic [AW-1:0]   ring_p;
	logic            is_front;

	rdq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rdq_cmp u_cmp (
		.mode     (cmp_mode),
		.cand     (ram_rdata),
		.ref_entry(cmp_ref),
		.hit      (cmp_hit)
	);

	assign empty    = count_q == '0;
	assign full     = count_q == CW'(DEPTH);
	assign is_front = (cmd_q.func == FN_POP_FRONT) || (cmd_q.func == FN_PEEK_FRONT);
	// back slot for a push, last record otherwise
	assign ring_off = (cmd_q.func == FN_PUSH_BACK) ? count_q : count_q - CW'(1);
	assign ring_p   = ring_add(front_q, ring_off);

	always_comb begin
		cmp_mode = (cmd_q.func == FN_MAX_AGE) ? CMP_AGE_GT : CMP_CODE_LT;
		cmp_ref  = best_q;
		if (state_q == S_DEL) begin
			cmp_mode     = CMP_CODE_NE;
			cmp_ref.code = cmd_q.record_code;
			cmp_ref.age  = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (start)
					state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_IDLE;
				if (!empty) begin
					case (cmd_q.func)
						FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
							state_d = S_POP;
						FN_MAX_AGE, FN_MIN_CODE:
							state_d = S_SCAN;
						FN_DELETE:
							state_d = S_DEL;
						default:
							state_d = S_IDLE;
					endcase
				end
			end
			S_POP:
				state_d = S_IDLE;
			S_SCAN, S_DEL:
				if (!vld_s1)
					state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		front_d   = front_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		wr_ptr_d  = wr_ptr_q;
		left_d    = left_q;
		kept_d    = kept_q;
		vld_d     = 1'b0;
		have_d    = have_q;
		best_d    = best_q;
		res_d     = res_q;
		done_d    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ring_p;
		ram_wdata.code = cmd_q.record_code;
		ram_wdata.age  = cmd_q.record_age;
		ram_raddr = ptr_q;

		case (state_q)
			S_EXEC: begin
				res_d.status   = STAT_OK;
				res_d.out_code = '0;
				res_d.out_age  = '0;
				res_d.count    = 7'(count_q);
				done_d         = 1'b1;
				case (cmd_q.func)
					FN_PUSH_FRONT, FN_PUSH_BACK:
						if (full) begin
							res_d.status = STAT_FULL;
						end else begin
							ram_we = 1'b1;
							if (cmd_q.func == FN_PUSH_FRONT) begin
								front_d   = ptr_dec(front_q);
								ram_waddr = front_d;
							end
							count_d     = count_q + CW'(1);
							res_d.count = 7'(count_d);
						end
					FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK,
					FN_MAX_AGE, FN_MIN_CODE, FN_DELETE:
						if (empty) begin
							res_d.status = STAT_EMPTY;
						end else begin
							done_d = 1'b0;
							vld_d  = 1'b1;
							have_d = 1'b0;
							left_d = count_q - CW'(1);
							kept_d = '0;
							if (cmd_q.func == FN_DELETE || is_front) begin
								ram_raddr = front_q;
								ptr_d     = ptr_inc(front_q);
								wr_ptr_d  = front_q;
							end else begin
								ram_raddr = ring_p;
								ptr_d     = ptr_dec(ring_p);
							end
						end
					FN_CLEAR: begin
						count_d     = '0;
						front_d     = '0;
						res_d.count = '0;
					end
					default: ;
				endcase
			end
			S_POP: begin
				res_d.status   = STAT_OK;
				res_d.out_code = ram_rdata.code;
				res_d.out_age  = ram_rdata.age;
				if (cmd_q.func == FN_POP_FRONT)
					front_d = ptr_inc(front_q);
				if (cmd_q.func == FN_POP_FRONT || cmd_q.func == FN_POP_BACK)
					count_d = count_q - CW'(1);
				res_d.count = 7'(count_d);
				done_d      = 1'b1;
			end
			S_SCAN: begin
				// walk back to front; strict compare keeps the tie nearest the back
				if (left_q != '0) begin
					ram_raddr = ptr_q;
					ptr_d     = ptr_dec(ptr_q);
					left_d    = left_q - CW'(1);
					vld_d     = 1'b1;
				end
				if (vld_s1) begin
					if (!have_q || cmp_hit)
						best_d = ram_rdata;
					have_d = 1'b1;
				end else begin
					res_d.status   = STAT_OK;
					res_d.out_code = best_q.code;
					res_d.out_age  = best_q.age;
					res_d.count    = 7'(count_q);
					done_d         = 1'b1;
				end
			end
			S_DEL: begin
				// compact survivors towards the front; writes never pass the reads
				if (left_q != '0) begin
					ram_raddr = ptr_q;
					ptr_d     = ptr_inc(ptr_q);
					left_d    = left_q - CW'(1);
					vld_d     = 1'b1;
				end
				if (vld_s1) begin
					if (cmp_hit) begin
						ram_we    = 1'b1;
						ram_waddr = wr_ptr_q;
						ram_wdata = ram_rdata;
						wr_ptr_d  = ptr_inc(wr_ptr_q);
						kept_d    = kept_q + CW'(1);
					end
				end else begin
					res_d.status   = (kept_q == count_q) ? STAT_NOT_FOUND : STAT_OK;
					res_d.out_code = '0;
					res_d.out_age  = '0;
					res_d.count    = 7'(kept_q);
					count_d        = kept_q;
					done_d         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			vld_s1  <= 1'b0;
			have_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			vld_s1  <= vld_d;
			have_q  <= have_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start)
			cmd_q <= cmd;
		ptr_q    <= ptr_d;
		wr_ptr_q <= wr_ptr_d;
		left_q   <= left_d;
		kept_q   <= kept_d;
		best_q   <= best_d;
		res_q    <= res_d;
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

`include "assert_macros.svh"

	`RDQ_ASSERT(a_done_idle, clk, arst_n, done |-> !busy)
	`RDQ_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`RDQ_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`RDQ_ASSERT(a_done_count, clk, arst_n, done |-> (result.count == 7'(count_q)))

endmodule
